// ===== sv/bida_pkg.sv =====
`timescale 1ns / 1ps

package bida_pkg;

	// default depth of the free list
	localparam int DEFAULT_MAX_BLOCKS = 1024;

	// fixed field widths
	localparam int BLK_W = 10;
	localparam int CNT_W = 11;
	localparam int ST_W  = 2;

	// reset value of the block count register
	localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

	// saturation limit of the free count field
	localparam logic [CNT_W-1:0] FREE_COUNT_MAX = 11'd2047;

	// request kinds
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [ST_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_NONE = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} ctrl_state_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic load_req;
		logic exec;
		logic load_res;
	} cmd_t;

endpackage

// ===== sv/block_id_allocator_core.sv =====
`timescale 1ns / 1ps

// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+---------------------------------------------
// request  | in        | s_tvalid/s_tready  | s_tdata: block_number; s_tuser: func
// result   | out       | m_tvalid/m_tready  | m_tdata: granted_block, free_count; m_tuser: status
// config   | in        | cfg_valid/cfg_ready| cfg_data: block_count
//
// each request goes through accept, execute and loading of the result register; the
// free list pop is a registered memory read
// reset clears the list pointers and counters and sets the block count to 1024; no clearing pass
// a finished result waits in the output register while the next request is accepted;
// a stalled result holds the sequencer in its last step until the register drains
// config writes are always taken

module block_id_allocator_core #(
	parameter int MAX_BLOCKS = bida_pkg::DEFAULT_MAX_BLOCKS
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] block_number, [15:10] zero
	input  logic        s_tuser,   // [0] func
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [9:0] granted_block, [20:10] free_count, [23:21] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	// block count register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);

	bida_pkg::cmd_t             cmd;
	logic [bida_pkg::BLK_W-1:0] granted_block;
	bida_pkg::status_t          status;
	logic [bida_pkg::CNT_W-1:0] free_count;

	assign cfg_ready = 1'b1;

	// sequencer: one request in flight, output beat handshake
	bida_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// free list memory, counters and result register
	bida_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_valid),
		.cfg_data      (cfg_data),
		.func          (s_tuser),
		.block_number  (s_tdata[bida_pkg::BLK_W-1:0]),
		.granted_block (granted_block),
		.status        (status),
		.free_count    (free_count)
	);

	assign m_tdata = {3'b000, free_count, granted_block};
	assign m_tuser = status;

endmodule

// ===== sv/bida_ctrl.sv =====
`timescale 1ns / 1ps

module bida_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output bida_pkg::cmd_t   cmd
);

	bida_pkg::ctrl_state_t state_q, state_d;
	logic                  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bida_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.load_req = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_res = 1'b0;
		case (state_q)
			bida_pkg::S_IDLE: begin
				s_tready     = 1'b1;
				cmd.load_req = s_tvalid;
				if (s_tvalid) begin
					state_d = bida_pkg::S_EXEC;
				end
			end
			bida_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = bida_pkg::S_DONE;
			end
			bida_pkg::S_DONE: begin
				// output register free or draining this cycle
				if (!out_valid_q || m_tready) begin
					cmd.load_res = 1'b1;
					state_d      = bida_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bida_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_res) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== sv/bida_dp.sv =====
`timescale 1ns / 1ps

module bida_dp #(
	parameter int MAX_BLOCKS = bida_pkg::DEFAULT_MAX_BLOCKS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bida_pkg::cmd_t             cmd,
	input  logic                       cfg_we,
	input  logic [bida_pkg::CNT_W-1:0] cfg_data,
	input  logic                       func,
	input  logic [bida_pkg::BLK_W-1:0] block_number,
	output logic [bida_pkg::BLK_W-1:0] granted_block,
	output bida_pkg::status_t          status,
	output logic [bida_pkg::CNT_W-1:0] free_count
);

	localparam int PTR_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LEN_W = $clog2(MAX_BLOCKS + 1);
	localparam int CMP_W = (LEN_W > bida_pkg::CNT_W) ? LEN_W : bida_pkg::CNT_W;
	localparam int SUM_W = CMP_W + 1;

	logic [bida_pkg::BLK_W-1:0] mem [MAX_BLOCKS];

	logic [bida_pkg::CNT_W-1:0] block_count_q;
	logic [PTR_W-1:0]           head_q, tail_q;
	logic [LEN_W-1:0]           len_q;
	logic [bida_pkg::CNT_W-1:0] next_q;

	logic                       func_q;
	logic [bida_pkg::BLK_W-1:0] num_q;
	logic [bida_pkg::BLK_W-1:0] rd_data_q;
	logic [bida_pkg::BLK_W-1:0] fresh_q;
	logic                       from_mem_q;
	bida_pkg::status_t          stat_q;

	logic [bida_pkg::BLK_W-1:0] gnt_res_q;
	bida_pkg::status_t          stat_res_q;
	logic [bida_pkg::CNT_W-1:0] cnt_res_q;

	logic [CMP_W-1:0]           bc_ext;
	logic [bida_pkg::CNT_W-1:0] eff_count;
	logic [bida_pkg::CNT_W-1:0] unused;
	logic [SUM_W-1:0]           total;
	logic [bida_pkg::CNT_W-1:0] cur_free;
	logic                       list_empty, list_full, fresh_ok;
	logic                       do_pop, do_fresh, do_push;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] idx);
		logic [PTR_W-1:0] nxt;
		nxt = (idx == PTR_W'(MAX_BLOCKS - 1)) ? '0 : idx + PTR_W'(1);
		return nxt;
	endfunction

	// block count clamped to the list depth; free count saturated at FREE_COUNT_MAX
	always_comb begin
		bc_ext    = CMP_W'(block_count_q);
		eff_count = (bc_ext > CMP_W'(MAX_BLOCKS)) ? bida_pkg::CNT_W'(MAX_BLOCKS)
		                                          : block_count_q;
		unused    = (eff_count > next_q) ? eff_count - next_q : '0;
		total     = SUM_W'(unused) + SUM_W'(len_q);
		cur_free  = (total > SUM_W'(bida_pkg::FREE_COUNT_MAX)) ? bida_pkg::FREE_COUNT_MAX
		                                                       : total[bida_pkg::CNT_W-1:0];
	end

	assign list_empty = (len_q == '0);
	assign list_full  = (len_q == LEN_W'(MAX_BLOCKS));
	assign fresh_ok   = (next_q < eff_count);
	assign do_pop     = cmd.exec && (func_q == bida_pkg::FUNC_ALLOC) && !list_empty;
	assign do_fresh   = cmd.exec && (func_q == bida_pkg::FUNC_ALLOC) && list_empty && fresh_ok;
	assign do_push    = cmd.exec && (func_q == bida_pkg::FUNC_FREE) && !list_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= bida_pkg::BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			block_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			len_q  <= '0;
			next_q <= '0;
		end else begin
			if (do_pop) begin
				head_q <= advance(head_q);
				len_q  <= len_q - LEN_W'(1);
			end
			if (do_push) begin
				tail_q <= advance(tail_q);
				len_q  <= len_q + LEN_W'(1);
			end
			if (do_fresh) begin
				next_q <= next_q + bida_pkg::CNT_W'(1);
			end
		end
	end

	// free list storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[tail_q] <= num_q;
		end
		if (do_pop) begin
			rd_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			func_q <= func;
			num_q  <= block_number;
		end
		if (cmd.exec) begin
			from_mem_q <= do_pop;
			fresh_q    <= do_fresh ? next_q[bida_pkg::BLK_W-1:0] : '0;
			if (func_q == bida_pkg::FUNC_ALLOC) begin
				stat_q <= (list_empty && !fresh_ok) ? bida_pkg::STAT_NONE : bida_pkg::STAT_OK;
			end else begin
				stat_q <= list_full ? bida_pkg::STAT_FULL : bida_pkg::STAT_OK;
			end
		end
		if (cmd.load_res) begin
			gnt_res_q  <= from_mem_q ? rd_data_q : fresh_q;
			stat_res_q <= stat_q;
			cnt_res_q  <= cur_free;
		end
	end

	assign granted_block = gnt_res_q;
	assign status        = stat_res_q;
	assign free_count    = cnt_res_q;

endmodule

// ===== verif/block_id_allocator_core_test.sv =====
`timescale 1ns / 1ps

module block_id_allocator_core_test;

	localparam int DEPTH = bida_pkg::DEFAULT_MAX_BLOCKS;
	localparam int BLK_W = bida_pkg::BLK_W;
	localparam int CNT_W = bida_pkg::CNT_W;

	// receiver stall patterns
	localparam int RX_ALWAYS   = 0;
	localparam int RX_RANDOM   = 1;
	localparam int RX_PERIODIC = 2;

	typedef struct {
		logic             func;
		logic [BLK_W-1:0] num;
	} request_t;

	typedef struct {
		logic [BLK_W-1:0]  granted;
		bida_pkg::status_t status;
		logic [CNT_W-1:0]  free_cnt;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [9:0] block_number, [15:10] zero
	logic        s_tuser = 1'b0; // [0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [9:0] granted_block, [20:10] free_count, [23:21] zero
	logic [1:0]  m_tuser;        // [1:0] status
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data = '0;

	block_id_allocator_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// shadow of the allocator state
	logic [BLK_W-1:0] fl_store [DEPTH];
	int               fl_head = 0;
	int               fl_tail = 0;
	int               fl_len = 0;
	int               next_fresh = 0;
	logic [CNT_W-1:0] blk_count = bida_pkg::BLOCK_COUNT_RST;

	request_t requests_to_send[$];
	grant_t   grants_due[$];
	request_t on_bus;
	grant_t   oldest_grant;

	int mismatches = 0;
	int gap_left = 0;
	int burst_left = 0;
	bit sender_idles = 1'b0;
	int rx_mode = RX_ALWAYS;
	int rx_tick = 0;

	// free-list allocator: pop the oldest freed id, else hand out a fresh id below the
	// clamped block count; free pushes any id unless the list is full
	function automatic grant_t serve_request(request_t rq);
		grant_t g;
		int lim;
		int fresh_left;
		int total;
		g.granted = '0;
		g.status = bida_pkg::STAT_OK;
		lim = (int'(blk_count) > DEPTH) ? DEPTH : int'(blk_count);
		if (rq.func == bida_pkg::FUNC_ALLOC) begin
			if (fl_len > 0) begin
				g.granted = fl_store[fl_head];
				fl_head = (fl_head + 1) % DEPTH;
				fl_len--;
			end else if (next_fresh < lim) begin
				g.granted = BLK_W'(next_fresh);
				next_fresh++;
			end else begin
				g.status = bida_pkg::STAT_NONE;
			end
		end else begin
			if (fl_len >= DEPTH) begin
				g.status = bida_pkg::STAT_FULL;
			end else begin
				fl_store[fl_tail] = rq.num;
				fl_tail = (fl_tail + 1) % DEPTH;
				fl_len++;
			end
		end
		// blocks cut off by a lowered count do not count as fresh
		fresh_left = (lim > next_fresh) ? lim - next_fresh : 0;
		total = fresh_left + fl_len;
		g.free_cnt = (total > int'(bida_pkg::FREE_COUNT_MAX)) ? bida_pkg::FREE_COUNT_MAX
		                                                      : CNT_W'(total);
		return g;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// 4 ns clock
	initial begin
		forever #2 clk = ~clk;
	end

	// request driver: with idling on, bursts of random length and random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			// beat taken: predict its result now
			if (s_tvalid && s_tready)
				grants_due.push_back(serve_request(on_bus));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (requests_to_send.size() > 0) begin
					on_bus = requests_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'b0, on_bus.num};
					s_tuser <= on_bus.func;
					if (sender_idles) begin
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(0, 15);
							gap_left = $urandom_range(1, 6);
						end
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor with its own stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_tick <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (grants_due.size() == 0) begin
					flag_mismatch("result beat with nothing pending", int'(m_tdata[9:0]), -1);
				end else begin
					oldest_grant = grants_due.pop_front();
					if (m_tdata[9:0] !== oldest_grant.granted)
						flag_mismatch("granted_block", int'(m_tdata[9:0]),
						              int'(oldest_grant.granted));
					if (m_tuser !== oldest_grant.status)
						flag_mismatch("status", int'(m_tuser), int'(oldest_grant.status));
					if (m_tdata[20:10] !== oldest_grant.free_cnt)
						flag_mismatch("free_count", int'(m_tdata[20:10]),
						              int'(oldest_grant.free_cnt));
				end
			end
			rx_tick <= rx_tick + 1;
			case (rx_mode)
				RX_ALWAYS: begin
					m_tready <= 1'b1;
				end
				RX_RANDOM: begin
					m_tready <= ($urandom_range(0, 99) < 65);
				end
				default: begin
					// the periodic pattern walks across every step of the request
					m_tready <= ((rx_tick % 7) >= 3);
				end
			endcase
		end
	end

	task automatic queue_req(logic func, logic [BLK_W-1:0] num);
		request_t rq;
		rq.func = func;
		rq.num = num;
		requests_to_send.push_back(rq);
	endtask

	task automatic queue_mix(int n, int alloc_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < alloc_pct)
				queue_req(bida_pkg::FUNC_ALLOC, BLK_W'($urandom_range(0, 1023)));
			else
				queue_req(bida_pkg::FUNC_FREE, BLK_W'($urandom_range(0, 1023)));
		end
	endtask

	// hold off until every beat is sent and every result is back, then idle a while;
	// checked between edges so the driver and monitor updates have settled
	task automatic settle();
		while (requests_to_send.size() != 0 || s_tvalid || grants_due.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_block_count(logic [CNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		blk_count = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_idling();
		sender_idles = $urandom_range(0, 1);
		rx_mode = $urandom_range(RX_RANDOM, RX_PERIODIC);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset block count: fresh ids, fifo order of freed ids, extreme numbers
		queue_req(bida_pkg::FUNC_ALLOC, '0);
		queue_req(bida_pkg::FUNC_ALLOC, '1);
		queue_req(bida_pkg::FUNC_ALLOC, '0);
		queue_req(bida_pkg::FUNC_FREE, 10'd1023);
		queue_req(bida_pkg::FUNC_FREE, 10'd0);
		queue_req(bida_pkg::FUNC_FREE, 10'h2aa);
		queue_req(bida_pkg::FUNC_FREE, 10'h155);
		queue_req(bida_pkg::FUNC_ALLOC, '0);
		queue_req(bida_pkg::FUNC_ALLOC, '0);
		queue_req(bida_pkg::FUNC_ALLOC, '0);
		queue_req(bida_pkg::FUNC_ALLOC, '0);
		queue_req(bida_pkg::FUNC_ALLOC, '0);
		settle();

		// count of zero, below the ids already used: nothing fresh, only freed ids
		write_block_count(11'd0);
		queue_req(bida_pkg::FUNC_ALLOC, '0);
		queue_req(bida_pkg::FUNC_FREE, 10'd5);
		queue_req(bida_pkg::FUNC_ALLOC, '0);
		queue_req(bida_pkg::FUNC_ALLOC, '0);
		settle();

		// count above the list depth is clamped
		write_block_count(11'd2047);
		queue_req(bida_pkg::FUNC_ALLOC, '0);
		queue_req(bida_pkg::FUNC_ALLOC, '0);
		queue_req(bida_pkg::FUNC_FREE, 10'd4);
		settle();

		// tiny pool: heavy churn, frequent exhaustion
		write_block_count(11'd2);
		pick_idling();
		queue_mix(150, 60);
		settle();

		// fill the free list to the top with no idling: full list, dropped frees
		write_block_count(11'd1024);
		sender_idles = 1'b0;
		rx_mode = RX_ALWAYS;
		for (int i = DEPTH - fl_len + 5; i > 0; i--)
			queue_req(bida_pkg::FUNC_FREE, BLK_W'($urandom_range(0, 1023)));
		for (int i = 0; i < 20; i++)
			queue_req(bida_pkg::FUNC_ALLOC, '0);
		settle();

		// any count
		write_block_count(CNT_W'($urandom_range(0, 2047)));
		pick_idling();
		queue_mix(130, 50);
		settle();

		write_block_count(11'd1023);
		pick_idling();
		queue_mix(100, 55);
		settle();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// hang guard
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
